// ===== hdl/euclidean_tour_length_unit_macros.svh =====
// Assertion macros shared by the tour length unit.
`ifndef EUCLIDEAN_TOUR_LENGTH_UNIT_MACROS_SVH
`define EUCLIDEAN_TOUR_LENGTH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked on each rising edge outside reset.
`define ETL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen on a rising edge outside reset.
`define ETL_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ETL_ASSERT(lbl, clk, rst_n, prop, msg)
`define ETL_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hdl/etl_pkg.sv =====
// Shared constants and types of the tour length unit.
package etl_pkg;

  localparam int MaxCities = 64;
  localparam int CityAw    = $clog2(MaxCities);
  localparam int CityW     = 6;
  localparam int CoordW    = 15;
  localparam int LegW      = 16;
  localparam int TotalW    = 22;
  localparam int SumW      = 2 * CoordW + 1;
  localparam int RootIters = (SumW + 1) / 2;
  localparam int IterW     = $clog2(RootIters);
  localparam int InDataW   = ((CityW + 2 * CoordW + 7) / 8) * 8;
  localparam int OutDataW  = ((LegW + TotalW + 7) / 8) * 8;

  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdVisit = 1'b1
  } cmd_e;

endpackage

// ===== hdl/etl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module etl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/euclidean_tour_length_unit.sv =====
// Tour length unit: city table, leg distance by iterative square root, running total.
//
// The slave stream carries one transaction per command. tuser bit 0 selects a
// load (0) or a visit (1); tuser bit 1 marks the first city of a tour and tlast
// the last one. A load writes the city's coordinates into the table in the
// cycle it is accepted and returns nothing; the next transaction is taken in
// the following cycle. A visit reads the table, squares and sums the two
// coordinate differences with one shared multiplier, and runs a bit-serial
// square root that retires two radicand bits per cycle. A visit steps through
// the read, difference, x square, y square, root, accumulate and done states,
// or only read, difference and done when it starts a tour, since no leg is
// measured then; the root loop is most of a measured visit. The next transaction
// is taken only when the block is back in idle. Each visit yields one master
// transaction with the leg, the saturating running total and tlast copied from
// the visit. The output register decouples the two sides: a new command is
// accepted while a result waits, and the block only stalls when a second
// result is ready before the first is taken. Reset clears the position and the
// total to zero; the city table is not cleared and must be loaded before it is read.
`include "euclidean_tour_length_unit_macros.svh"

module euclidean_tour_length_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // city_index [5:0], coord_x [20:6], coord_y [35:21], zero fill above
  input  logic [etl_pkg::InDataW-1:0]  s_axis_tdata_i,
  // cmd [0], tour_start [1]
  input  logic [1:0]                   s_axis_tuser_i,
  // tour_end
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // leg_distance [15:0], tour_total [37:16], zero fill above
  output logic [etl_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tour_done
  output logic                         m_axis_tlast_o
);

  localparam int CW = etl_pkg::CoordW;
  localparam int SW = etl_pkg::SumW;
  localparam int LW = etl_pkg::LegW;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiff,
    StSqx,
    StSqy,
    StRoot,
    StAcc,
    StDone
  } state_e;

  state_e state_q, state_d;

  logic [etl_pkg::CityW-1:0]  city_q, city_d;
  logic                       in_range_q, in_range_d;
  logic                       start_q, start_d;
  logic                       end_q, end_d;
  logic [CW-1:0]              cur_x_q, cur_x_d;
  logic [CW-1:0]              cur_y_q, cur_y_d;
  logic [CW-1:0]              dx_q, dx_d;
  logic [CW-1:0]              dy_q, dy_d;
  logic [SW-1:0]              rem_q, rem_d;
  logic [SW-1:0]              root_q, root_d;
  logic [SW-1:0]              bit_q, bit_d;
  logic [etl_pkg::IterW-1:0]  iter_q, iter_d;
  logic [etl_pkg::LegW-1:0]   leg_q, leg_d;
  logic [etl_pkg::TotalW-1:0] total_q, total_d;
  logic                       out_valid_q, out_valid_d;
  logic [etl_pkg::LegW-1:0]   out_leg_q, out_leg_d;
  logic [etl_pkg::TotalW-1:0] out_total_q, out_total_d;
  logic                       out_last_q, out_last_d;

  logic                       in_fire;
  logic                       in_visit;
  logic                       in_load;
  etl_pkg::cmd_e              in_cmd;
  logic [etl_pkg::CityW-1:0]  in_city;
  logic [CW-1:0]              in_x;
  logic [CW-1:0]              in_y;
  logic                       in_city_ok;
  logic [2*CW-1:0]            ram_rdata;
  logic [CW-1:0]              nx;
  logic [CW-1:0]              ny;
  logic [CW-1:0]              mul_op;
  logic [2*CW-1:0]            product;
  logic [SW:0]                trial;
  logic [etl_pkg::TotalW:0]   total_sum;
  logic                       out_free;

  assign in_cmd     = etl_pkg::cmd_e'(s_axis_tuser_i[0]);
  assign in_city    = s_axis_tdata_i[etl_pkg::CityW-1:0];
  assign in_x       = s_axis_tdata_i[etl_pkg::CityW +: CW];
  assign in_y       = s_axis_tdata_i[etl_pkg::CityW + CW +: CW];
  assign in_city_ok = 32'(in_city) < 32'(etl_pkg::MaxCities);

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_visit        = in_fire && (in_cmd == etl_pkg::CmdVisit);
  assign in_load         = in_fire && (in_cmd == etl_pkg::CmdLoad) && in_city_ok;

  etl_ram #(
    .Width (2 * CW),
    .Depth (etl_pkg::MaxCities)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (in_load),
    .waddr_i (etl_pkg::CityAw'(in_city)),
    .wdata_i ({in_y, in_x}),
    .raddr_i (etl_pkg::CityAw'(city_q)),
    .rdata_o (ram_rdata)
  );

  // A city beyond the table reads as the origin.
  assign nx = in_range_q ? ram_rdata[CW-1:0]  : '0;
  assign ny = in_range_q ? ram_rdata[2*CW-1:CW] : '0;

  // One multiplier serves both squares.
  assign mul_op  = (state_q == StSqx) ? dx_q : dy_q;
  assign product = mul_op * mul_op;

  assign trial     = {1'b0, root_q} + {1'b0, bit_q};
  assign total_sum = {1'b0, total_q} + (etl_pkg::TotalW + 1)'(leg_q);
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    city_d      = city_q;
    in_range_d  = in_range_q;
    start_d     = start_q;
    end_d       = end_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    iter_d      = iter_q;
    leg_d       = leg_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_leg_d   = out_leg_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_visit) begin
          city_d     = in_city;
          in_range_d = in_city_ok;
          start_d    = s_axis_tuser_i[1];
          end_d      = s_axis_tlast_i;
          state_d    = StRead;
        end
      end
      StRead: begin
        state_d = StDiff;
      end
      StDiff: begin
        dx_d    = (nx >= cur_x_q) ? nx - cur_x_q : cur_x_q - nx;
        dy_d    = (ny >= cur_y_q) ? ny - cur_y_q : cur_y_q - ny;
        cur_x_d = nx;
        cur_y_d = ny;
        if (start_q) begin
          leg_d   = '0;
          total_d = '0;
          state_d = StDone;
        end else begin
          state_d = StSqx;
        end
      end
      StSqx: begin
        rem_d   = SW'(product);
        state_d = StSqy;
      end
      StSqy: begin
        rem_d   = rem_q + SW'(product);
        root_d  = '0;
        bit_d   = SW'(1) << (SW - 1);
        iter_d  = '0;
        state_d = StRoot;
      end
      StRoot: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = rem_q - trial[SW-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        iter_d = iter_q + 1'b1;
        if (iter_q == etl_pkg::IterW'(etl_pkg::RootIters - 1)) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        leg_d   = root_q[LW-1:0];
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          // Saturate only on legs measured here; a tour start cleared the total.
          if (!start_q && total_sum[etl_pkg::TotalW]) begin
            out_total_d = etl_pkg::TotalMax;
            total_d     = etl_pkg::TotalMax;
          end else if (!start_q) begin
            out_total_d = total_sum[etl_pkg::TotalW-1:0];
            total_d     = total_sum[etl_pkg::TotalW-1:0];
          end else begin
            out_total_d = total_q;
          end
          out_leg_d   = leg_q;
          out_last_d  = end_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      city_q      <= '0;
      in_range_q  <= 1'b0;
      start_q     <= 1'b0;
      end_q       <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      iter_q      <= '0;
      leg_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_leg_q   <= '0;
      out_total_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      city_q      <= city_d;
      in_range_q  <= in_range_d;
      start_q     <= start_d;
      end_q       <= end_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      rem_q       <= rem_d;
      root_q      <= root_d;
      bit_q       <= bit_d;
      iter_q      <= iter_d;
      leg_q       <= leg_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      out_leg_q   <= out_leg_d;
      out_total_q <= out_total_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = etl_pkg::OutDataW'({out_total_q, out_leg_q});
  assign m_axis_tlast_o  = out_last_q;

  `ETL_ASSERT(a_visit_blocks, clk_i, rst_ni, in_visit |=> !s_axis_tready_o, "input not held off")
  `ETL_NEVER(a_root_fits, clk_i, rst_ni, (state_q == StAcc) && |root_q[SW-1:LW], "root overflow")
  `ETL_ASSERT(a_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == StDone), "no visit")

endmodule

// ===== dv/euclidean_tour_length_unit_test.sv =====
// Self-checking stream testbench for the tour length unit with its own tour predictor.
module euclidean_tour_length_unit_test;

  localparam int CityW     = etl_pkg::CityW;
  localparam int CoordW    = etl_pkg::CoordW;
  localparam int LegW      = etl_pkg::LegW;
  localparam int TotalW    = etl_pkg::TotalW;
  localparam int InDataW   = etl_pkg::InDataW;
  localparam int OutDataW  = etl_pkg::OutDataW;
  localparam int MaxCities = etl_pkg::MaxCities;

  localparam int ItemTarget     = 1350;
  localparam int TailItems      = 150;
  localparam int LongHoldAt     = 300;
  localparam int LongHoldCycles = 400;
  localparam int SettleCycles   = 64;
  localparam int CycleLimit     = 400000;

  typedef struct packed {
    etl_pkg::cmd_e     cmd;
    logic [CityW-1:0]  city;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              start;
    logic              fin;
    logic              drain;
  } tour_cmd_t;

  typedef struct packed {
    logic [LegW-1:0]   leg;
    logic [TotalW-1:0] total;
    logic              done;
  } leg_result_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic [1:0]          s_tuser  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  tour_cmd_t   cmd_q[$];
  leg_result_t legs_due[$];
  tour_cmd_t   cur_cmd;
  logic        drain_next;
  logic        city_loaded [MaxCities];

  // Predictor state.
  logic [CoordW-1:0] city_x [MaxCities];
  logic [CoordW-1:0] city_y [MaxCities];
  logic [CoordW-1:0] pos_x = '0;
  logic [CoordW-1:0] pos_y = '0;
  logic [TotalW-1:0] track_total = '0;

  int errors       = 0;
  int taken_cnt    = 0;
  int cycles       = 0;
  int gap_left     = 0;
  int send_stretch = 0;
  int send_odds    = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int recv_stretch = 0;
  int recv_odds    = 0;
  logic long_hold_done = 1'b0;

  euclidean_tour_length_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Truncated square root, two radicand bits per step.
  function automatic logic [LegW-1:0] root_floor(input logic [31:0] radicand);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    int          i;
    rem   = radicand;
    root  = '0;
    probe = 32'h4000_0000;
    for (i = 0; i < 16; i++) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[LegW-1:0];
  endfunction

  task automatic score_command(input tour_cmd_t c);
    logic [CoordW-1:0] nx;
    logic [CoordW-1:0] ny;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [31:0]       radicand;
    logic [TotalW:0]   sum;
    leg_result_t       r;
    if (c.cmd == etl_pkg::CmdLoad) begin
      city_x[c.city] = c.x;
      city_y[c.city] = c.y;
    end else begin
      nx    = city_x[c.city];
      ny    = city_y[c.city];
      r.leg = '0;
      if (c.start) begin
        track_total = '0;
      end else begin
        dx       = (nx >= pos_x) ? nx - pos_x : pos_x - nx;
        dy       = (ny >= pos_y) ? ny - pos_y : pos_y - ny;
        radicand = 32'(dx) * 32'(dx) + 32'(dy) * 32'(dy);
        r.leg    = root_floor(radicand);
        sum      = {1'b0, track_total} + (TotalW + 1)'(r.leg);
        track_total = (sum > etl_pkg::TotalMax) ? etl_pkg::TotalMax : sum[TotalW-1:0];
      end
      pos_x   = nx;
      pos_y   = ny;
      r.total = track_total;
      r.done  = c.fin;
      legs_due = {legs_due, r};
    end
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    if ($urandom_range(0, 9) < 6) return CoordW'($urandom_range(0, (1 << CoordW) - 1));
    return CoordW'($urandom_range(0, 25600));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [CityW-1:0] rand_city();
    return CityW'($urandom_range(0, MaxCities - 1));
  endfunction

  // Only cities that were loaded are ever visited.
  function automatic logic [CityW-1:0] pick_loaded();
    logic [CityW-1:0] c;
    c = rand_city();
    while (!city_loaded[c]) c = rand_city();
    return c;
  endfunction

  task automatic push_cmd(input etl_pkg::cmd_e cmd, input logic [CityW-1:0] city,
                          input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                          input logic start, input logic fin);
    tour_cmd_t c;
    c.cmd   = cmd;
    c.city  = city;
    c.x     = x;
    c.y     = y;
    c.start = start;
    c.fin   = fin;
    c.drain = drain_next;
    drain_next = 1'b0;
    if (cmd == etl_pkg::CmdLoad) city_loaded[city] = 1'b1;
    cmd_q = {cmd_q, c};
  endtask

  task automatic add_tour(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      push_cmd(etl_pkg::CmdVisit, pick_loaded(), rand_coord(), rand_coord(), k == 0,
               k == len - 1);
    end
  endtask

  task automatic build_stimulus();
    int               kind;
    int               len;
    int               k;
    int               walks;
    logic             flavor;
    logic [CityW-1:0] ca;
    logic [CityW-1:0] cb;
    drain_next = 1'b0;
    for (k = 0; k < MaxCities; k++) city_loaded[k] = 1'b0;

    // Directed part: loads carry tour flags that must be ignored.
    push_cmd(etl_pkg::CmdLoad, 6'd0, 15'd0, 15'd0, 1'b1, 1'b1);
    push_cmd(etl_pkg::CmdLoad, 6'd63, 15'h7FFF, 15'h7FFF, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdLoad, 6'd1, 15'd25600, 15'd25600, 1'b0, 1'b1);
    push_cmd(etl_pkg::CmdLoad, 6'd2, 15'd25600, 15'd0, 1'b1, 1'b0);
    push_cmd(etl_pkg::CmdLoad, 6'd3, 15'h5555, 15'h2AAA, 1'b0, 1'b0);
    // Visits without a tour start measure from the reset position.
    push_cmd(etl_pkg::CmdVisit, 6'd0, 15'h7FFF, 15'h7FFF, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd63, 15'h0, 15'h0, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd0, 15'h0, 15'h0, 1'b1, 1'b1);
    push_cmd(etl_pkg::CmdVisit, 6'd1, 15'h0, 15'h0, 1'b1, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd2, 15'h0, 15'h0, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd3, 15'h0, 15'h0, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd63, 15'h0, 15'h0, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd0, 15'h0, 15'h0, 1'b0, 1'b1);
    // After a tour end the total keeps accumulating.
    push_cmd(etl_pkg::CmdVisit, 6'd2, 15'h0, 15'h0, 1'b0, 1'b0);
    drain_next = 1'b1;
    push_cmd(etl_pkg::CmdLoad, 6'd0, 15'h2AAA, 15'h5555, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd0, 15'h0, 15'h0, 1'b1, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd0, 15'h0, 15'h0, 1'b0, 1'b1);
    push_cmd(etl_pkg::CmdLoad, 6'd4, 15'h7FFF, 15'h0, 1'b1, 1'b1);
    push_cmd(etl_pkg::CmdVisit, 6'd4, 15'h0, 15'h0, 1'b0, 1'b0);
    push_cmd(etl_pkg::CmdVisit, 6'd3, 15'h0, 15'h0, 1'b0, 1'b1);

    walks = 0;
    while (cmd_q.size() < ItemTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(0, 2);
        repeat (len) push_cmd(etl_pkg::CmdLoad, rand_city(), rand_coord(), rand_coord(),
                              rand_bit(), rand_bit());
        add_tour($urandom_range(1, 12));
      end else if (kind < 60) begin
        len = $urandom_range(1, 4);
        repeat (len) push_cmd(etl_pkg::CmdLoad, rand_city(), rand_coord(), rand_coord(),
                              rand_bit(), rand_bit());
      end else if (kind < 80) begin
        push_cmd(etl_pkg::CmdVisit, pick_loaded(), rand_coord(), rand_coord(), rand_bit(),
                 rand_bit());
      end else if (kind < 90) begin
        // Tour missing either its start or its end.
        len    = $urandom_range(2, 6);
        flavor = rand_bit();
        for (k = 0; k < len; k++) begin
          push_cmd(etl_pkg::CmdVisit, pick_loaded(), rand_coord(), rand_coord(),
                   flavor && k == 0, !flavor && k == len - 1);
        end
      end else if (kind < 93 && walks < 2) begin
        // Back and forth between opposite corners until the total saturates.
        walks++;
        ca = rand_city();
        cb = ca ^ 6'h01;
        push_cmd(etl_pkg::CmdLoad, ca, CoordW'($urandom_range(0, 255)),
                 CoordW'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_cmd(etl_pkg::CmdLoad, cb, CoordW'(32767 - $urandom_range(0, 255)),
                 CoordW'(32767 - $urandom_range(0, 255)), 1'b0, 1'b0);
        for (k = 0; k < 100; k++) begin
          push_cmd(etl_pkg::CmdVisit, k[0] ? cb : ca, rand_coord(), rand_coord(), k == 0,
                   k == 99);
        end
      end else begin
        // Keep the long receiver hold clear of sender pauses.
        drain_next = (cmd_q.size() < 250 || cmd_q.size() > 800);
        add_tour($urandom_range(1, 8));
      end
    end
  endtask

  // Driver: offers the next pending command and holds it until taken.
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        score_command(cur_cmd);
        taken_cnt++;
        offer = 1'b0;
      end
      if (send_stretch == 0) begin
        send_stretch = $urandom_range(40, 300);
        case ($urandom_range(0, 2))
          0:       send_odds = 0;
          1:       send_odds = 10;
          default: send_odds = 35;
        endcase
      end else begin
        send_stretch--;
      end
      if (gap_left > 0) gap_left--;
      if (!offer && gap_left == 0 && cmd_q.size() > 0 &&
          !(cmd_q[0].drain && legs_due.size() != 0)) begin
        if (cmd_q.size() >= TailItems && hold_left == 0 &&
            $urandom_range(0, 99) < send_odds) begin
          gap_left = $urandom_range(1, 11);
        end else begin
          cur_cmd = cmd_q.pop_front();
          offer   = 1'b1;
          s_tdata <= InDataW'({cur_cmd.y, cur_cmd.x, cur_cmd.city});
          s_tuser <= {cur_cmd.start, cur_cmd.cmd};
          s_tlast <= cur_cmd.fin;
        end
      end
      s_tvalid <= offer;
    end
  end

  // Receiver backpressure, with one long hold so the block fills up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (recv_stretch == 0) begin
        recv_stretch = $urandom_range(40, 300);
        recv_odds    = $urandom_range(0, 2) * 15;
      end else begin
        recv_stretch--;
      end
      if (hold_left > 0) hold_left--;
      if (stall_left > 0) stall_left--;
      if (!long_hold_done && taken_cnt >= LongHoldAt) begin
        long_hold_done = 1'b1;
        hold_left      = LongHoldCycles;
      end else if (stall_left == 0 && hold_left == 0 && cmd_q.size() >= TailItems &&
                   $urandom_range(0, 99) < recv_odds) begin
        stall_left = $urandom_range(1, 11);
      end
      m_tready <= (stall_left == 0 && hold_left == 0);
    end
  end

  // Monitor: each result transaction is checked against the oldest expected leg.
  always @(posedge clk_i) begin
    leg_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (legs_due.size() == 0) begin
        report("unexpected result, leg_distance", m_tdata[LegW-1:0], 0);
      end else begin
        want = legs_due.pop_front();
        if (m_tdata[LegW-1:0] !== want.leg)
          report("leg_distance", m_tdata[LegW-1:0], want.leg);
        if (m_tdata[LegW +: TotalW] !== want.total)
          report("tour_total", m_tdata[LegW +: TotalW], want.total);
        if (m_tlast !== want.done)
          report("tour_done", m_tlast, want.done);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("euclidean_tour_length_unit_test: FAIL");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (legs_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("euclidean_tour_length_unit_test: PASS");
    end else begin
      $display("euclidean_tour_length_unit_test: FAIL");
    end
    $finish;
  end

endmodule
